// ----- rtl/stu_pkg.sv -----
package stu_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POLARITY = 3'd5;

    // register widths
    localparam int GAIN_W  = 18;
    localparam int PAN_W   = 18;
    localparam int WIDTH_W = 18;
    localparam int ALPHA_W = 16;
    localparam int MODE_W  = 2;
    localparam int POL_W   = 2;

    // stereo modes, code three behaves as stereo
    localparam logic [MODE_W-1:0] MODE_STEREO   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MONO     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOW_MONO = 2'd2;

    // polarity bits
    localparam int POL_LEFT  = 0;
    localparam int POL_RIGHT = 1;

    // reset values
    localparam logic [GAIN_W-1:0]  GAIN_RST  = 18'd65536;
    localparam logic [PAN_W-1:0]   PAN_RST   = 18'd0;
    localparam logic [WIDTH_W-1:0] WIDTH_RST = 18'd65536;
    localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd1021;
    localparam logic [MODE_W-1:0]  MODE_RST  = MODE_STEREO;
    localparam logic [POL_W-1:0]   POL_RST   = 2'd0;

endpackage

// ----- rtl/stereo_utility_stage_unit.sv -----
// stereo utility stage: polarity, gain, mid/side width, mono or bass mono, pan
// a new pair is taken only in idle; in_stall stays high while a pair is in flight and
// until its result is loaded into the output register; one shared multiplier with a
// product register serves every coefficient product, each in a multiply and a write state
// reset: async active low, registers to defaults, bass filter states to zero
module stereo_utility_stage_unit #(
    parameter int SAMPLE_BITS    = 25,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [SAMPLE_BITS-1:0]     left_in,
    input  logic signed [SAMPLE_BITS-1:0]     right_in,
    input  logic                              right_present,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [SAMPLE_BITS-1:0]     left_out,
    output logic signed [SAMPLE_BITS-1:0]     right_out,
    output logic                              right_valid,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [stu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [stu_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // datapath width: headroom for gain up to 64x at the smallest fraction width
    localparam int W  = SAMPLE_BITS + 10;
    localparam int CW = (COEF_FRAC_BITS + 2 > 19) ? COEF_FRAC_BITS + 2 : 19;
    localparam int PW = W + CW;

    localparam logic signed [CW-1:0] COEF_ONE =
        {{(CW-COEF_FRAC_BITS-1){1'b0}}, 1'b1, {COEF_FRAC_BITS{1'b0}}};
    localparam logic signed [CW-1:0] COEF_TWO = COEF_ONE <<< 1;
    localparam logic signed [PW-1:0] RND_HALF =
        {{(PW-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
    localparam logic signed [W-1:0] SAT_HI = {{(W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [W-1:0] SAT_LO = {{(W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    // sequencer states
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_GL_M  = 5'd1;
    localparam logic [4:0] ST_GL_W  = 5'd2;
    localparam logic [4:0] ST_GR_M  = 5'd3;
    localparam logic [4:0] ST_GR_W  = 5'd4;
    localparam logic [4:0] ST_MS    = 5'd5;
    localparam logic [4:0] ST_SW_M  = 5'd6;
    localparam logic [4:0] ST_SW_W  = 5'd7;
    localparam logic [4:0] ST_F1L_M = 5'd8;
    localparam logic [4:0] ST_F1L_W = 5'd9;
    localparam logic [4:0] ST_F2L_M = 5'd10;
    localparam logic [4:0] ST_F2L_W = 5'd11;
    localparam logic [4:0] ST_F1R_M = 5'd12;
    localparam logic [4:0] ST_F1R_W = 5'd13;
    localparam logic [4:0] ST_F2R_M = 5'd14;
    localparam logic [4:0] ST_F2R_W = 5'd15;
    localparam logic [4:0] ST_LOW   = 5'd16;
    localparam logic [4:0] ST_PL_M  = 5'd17;
    localparam logic [4:0] ST_PL_W  = 5'd18;
    localparam logic [4:0] ST_PR_M  = 5'd19;
    localparam logic [4:0] ST_PR_W  = 5'd20;
    localparam logic [4:0] ST_DONE  = 5'd21;

    logic [4:0] state_reg, state_next;

    logic [stu_pkg::GAIN_W-1:0]  gain_reg;
    logic [stu_pkg::PAN_W-1:0]   pan_reg;
    logic [stu_pkg::WIDTH_W-1:0] width_reg;
    logic [stu_pkg::ALPHA_W-1:0] alpha_reg;
    logic [stu_pkg::MODE_W-1:0]  mode_reg;
    logic [stu_pkg::POL_W-1:0]   pol_reg;

    logic signed [W-1:0] s1l_reg, s2l_reg, s1r_reg, s2r_reg;
    logic signed [W-1:0] l_reg, r_reg, mid_reg, side_reg;
    logic                present_reg;
    logic signed [PW-1:0] prod_reg;

    logic                           out_valid_reg;
    logic signed [SAMPLE_BITS-1:0]  left_out_reg, right_out_reg;
    logic                           right_valid_reg;

    logic signed [CW-1:0] gain_c, alpha_c, width_ext, width_c;
    logic signed [CW-1:0] pan_ext, pan_c, pgl_c, pgr_c;
    logic signed [W-1:0]  l_ext, r_ext;
    logic signed [W-1:0]  diff_a, diff_b, fdiff;
    logic signed [W-1:0]  mul_a;
    logic signed [CW-1:0] mul_c;
    logic signed [PW-1:0] rnd_sum;
    logic signed [W-1:0]  rnd;
    logic signed [W:0]    ms_sum, ms_diff, lm_sum;
    logic signed [W-1:0]  low_mid;
    logic                 in_accept, out_load;
    logic signed [SAMPLE_BITS-1:0] l_sat, r_sat;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    assign out_valid   = out_valid_reg;
    assign left_out    = left_out_reg;
    assign right_out   = right_out_reg;
    assign right_valid = right_valid_reg;

    // coefficient conditioning
    assign gain_c    = {{(CW-stu_pkg::GAIN_W){1'b0}}, gain_reg};
    assign alpha_c   = {{(CW-stu_pkg::ALPHA_W){1'b0}}, alpha_reg};
    assign width_ext = {{(CW-stu_pkg::WIDTH_W){1'b0}}, width_reg};
    assign width_c   = (width_ext > COEF_TWO) ? COEF_TWO : width_ext;
    assign pan_ext   = {{(CW-stu_pkg::PAN_W){pan_reg[stu_pkg::PAN_W-1]}}, pan_reg};

    always_comb
    begin
        if (pan_ext > COEF_ONE)
        begin
            pan_c = COEF_ONE;
        end
        else if (pan_ext < -COEF_ONE)
        begin
            pan_c = -COEF_ONE;
        end
        else
        begin
            pan_c = pan_ext;
        end
    end

    assign pgl_c = (pan_c[CW-1] || pan_c == '0) ? COEF_ONE : COEF_ONE - pan_c;
    assign pgr_c = pan_c[CW-1] ? COEF_ONE + pan_c : COEF_ONE;

    // input capture, right path takes left when no right channel exists
    assign l_ext = {{(W-SAMPLE_BITS){left_in[SAMPLE_BITS-1]}}, left_in};
    assign r_ext = right_present ? {{(W-SAMPLE_BITS){right_in[SAMPLE_BITS-1]}}, right_in}
                                 : l_ext;

    // shared multiplier operand select
    always_comb
    begin
        diff_a = l_reg;
        diff_b = s1l_reg;
        mul_a  = l_reg;
        mul_c  = gain_c;
        case (state_reg)
            ST_GR_M:
            begin
                mul_a = r_reg;
            end
            ST_SW_M:
            begin
                mul_a = side_reg;
                mul_c = width_c;
            end
            ST_F1L_M:
            begin
                mul_a = fdiff;
                mul_c = alpha_c;
            end
            ST_F2L_M:
            begin
                diff_a = s1l_reg;
                diff_b = s2l_reg;
                mul_a  = fdiff;
                mul_c  = alpha_c;
            end
            ST_F1R_M:
            begin
                diff_a = r_reg;
                diff_b = s1r_reg;
                mul_a  = fdiff;
                mul_c  = alpha_c;
            end
            ST_F2R_M:
            begin
                diff_a = s1r_reg;
                diff_b = s2r_reg;
                mul_a  = fdiff;
                mul_c  = alpha_c;
            end
            ST_PL_M:
            begin
                mul_c = pgl_c;
            end
            ST_PR_M:
            begin
                mul_a = r_reg;
                mul_c = pgr_c;
            end
            default:
            begin
                mul_a = l_reg;
            end
        endcase
    end

    assign fdiff = diff_a - diff_b;

    // round half up after the product register
    assign rnd_sum = prod_reg + RND_HALF;
    assign rnd     = rnd_sum[COEF_FRAC_BITS +: W];

    assign ms_sum  = {l_reg[W-1], l_reg} + {r_reg[W-1], r_reg} + {{W{1'b0}}, 1'b1};
    assign ms_diff = {l_reg[W-1], l_reg} - {r_reg[W-1], r_reg} + {{W{1'b0}}, 1'b1};
    assign lm_sum  = {s2l_reg[W-1], s2l_reg} + {s2r_reg[W-1], s2r_reg} + {{W{1'b0}}, 1'b1};
    assign low_mid = lm_sum[W:1];

    assign l_sat = (l_reg > SAT_HI) ? SAT_HI[SAMPLE_BITS-1:0] :
                   (l_reg < SAT_LO) ? SAT_LO[SAMPLE_BITS-1:0] : l_reg[SAMPLE_BITS-1:0];
    assign r_sat = (r_reg > SAT_HI) ? SAT_HI[SAMPLE_BITS-1:0] :
                   (r_reg < SAT_LO) ? SAT_LO[SAMPLE_BITS-1:0] : r_reg[SAMPLE_BITS-1:0];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_accept) state_next = ST_GL_M;
            ST_GL_M:  state_next = ST_GL_W;
            ST_GL_W:  state_next = ST_GR_M;
            ST_GR_M:  state_next = ST_GR_W;
            ST_GR_W:  state_next = ST_MS;
            ST_MS:    state_next = ST_SW_M;
            ST_SW_M:  state_next = ST_SW_W;
            ST_SW_W:  state_next = (mode_reg == stu_pkg::MODE_LOW_MONO) ? ST_F1L_M : ST_PL_M;
            ST_F1L_M: state_next = ST_F1L_W;
            ST_F1L_W: state_next = ST_F2L_M;
            ST_F2L_M: state_next = ST_F2L_W;
            ST_F2L_W: state_next = ST_F1R_M;
            ST_F1R_M: state_next = ST_F1R_W;
            ST_F1R_W: state_next = ST_F2R_M;
            ST_F2R_M: state_next = ST_F2R_W;
            ST_F2R_W: state_next = ST_LOW;
            ST_LOW:   state_next = ST_PL_M;
            ST_PL_M:  state_next = ST_PL_W;
            ST_PL_W:  state_next = ST_PR_M;
            ST_PR_M:  state_next = ST_PR_W;
            ST_PR_W:  state_next = ST_DONE;
            ST_DONE:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= stu_pkg::GAIN_RST;
            pan_reg   <= stu_pkg::PAN_RST;
            width_reg <= stu_pkg::WIDTH_RST;
            alpha_reg <= stu_pkg::ALPHA_RST;
            mode_reg  <= stu_pkg::MODE_RST;
            pol_reg   <= stu_pkg::POL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                stu_pkg::CFG_GAIN:     gain_reg  <= cfg_data[stu_pkg::GAIN_W-1:0];
                stu_pkg::CFG_PAN:      pan_reg   <= cfg_data[stu_pkg::PAN_W-1:0];
                stu_pkg::CFG_WIDTH:    width_reg <= cfg_data[stu_pkg::WIDTH_W-1:0];
                stu_pkg::CFG_ALPHA:    alpha_reg <= cfg_data[stu_pkg::ALPHA_W-1:0];
                stu_pkg::CFG_MODE:     mode_reg  <= cfg_data[stu_pkg::MODE_W-1:0];
                stu_pkg::CFG_POLARITY: pol_reg   <= cfg_data[stu_pkg::POL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // bass filter states
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1l_reg <= '0;
            s2l_reg <= '0;
            s1r_reg <= '0;
            s2r_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_F1L_W: s1l_reg <= s1l_reg + rnd;
                ST_F2L_W: s2l_reg <= s2l_reg + rnd;
                ST_F1R_W: s1r_reg <= s1r_reg + rnd;
                ST_F2R_W: s2r_reg <= s2r_reg + rnd;
                default:
                begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_c;
        if (in_accept)
        begin
            l_reg       <= pol_reg[stu_pkg::POL_LEFT]  ? -l_ext : l_ext;
            r_reg       <= pol_reg[stu_pkg::POL_RIGHT] ? -r_ext : r_ext;
            present_reg <= right_present;
        end
        else
        begin
            case (state_reg)
                ST_GL_W: l_reg <= rnd;
                ST_GR_W: r_reg <= rnd;
                ST_MS:
                begin
                    mid_reg  <= ms_sum[W:1];
                    side_reg <= ms_diff[W:1];
                end
                ST_SW_W:
                begin
                    if (mode_reg == stu_pkg::MODE_MONO)
                    begin
                        l_reg <= mid_reg;
                        r_reg <= mid_reg;
                    end
                    else
                    begin
                        l_reg <= mid_reg + rnd;
                        r_reg <= mid_reg - rnd;
                    end
                end
                ST_LOW:
                begin
                    l_reg <= low_mid + l_reg - s2l_reg;
                    r_reg <= low_mid + r_reg - s2r_reg;
                end
                ST_PL_W: l_reg <= rnd;
                ST_PR_W: r_reg <= rnd;
                default:
                begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            left_out_reg    <= l_sat;
            right_out_reg   <= present_reg ? r_sat : '0;
            right_valid_reg <= present_reg;
        end
    end

endmodule

// ----- sim/stereo_stage_checker.sv -----
`timescale 1ns / 100ps

module stereo_stage_checker #(
    parameter int SAMPLE_BITS    = 25,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic signed [SAMPLE_BITS-1:0]       left_in,
    input  logic signed [SAMPLE_BITS-1:0]       right_in,
    input  logic                                right_present,

    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [SAMPLE_BITS-1:0]       left_out,
    input  logic signed [SAMPLE_BITS-1:0]       right_out,
    input  logic                                right_valid,

    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [stu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [stu_pkg::CFG_DATA_W-1:0]      cfg_data,

    output int                                  pending_results,
    output int                                  fail_count
);

    import stu_pkg::*;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
        logic                          rvalid;
    } stereo_pair_t;

    // register copies
    logic [GAIN_W-1:0]         gain_reg;
    logic signed [PAN_W-1:0]   pan_reg;
    logic [WIDTH_W-1:0]        width_reg;
    logic [ALPHA_W-1:0]        alpha_reg;
    logic [MODE_W-1:0]         mode_reg;
    logic [POL_W-1:0]          pol_reg;

    // bass filter states, two cascaded one-poles per channel
    longint lp_left_a, lp_left_b, lp_right_a, lp_right_b;

    stereo_pair_t expected_pairs[$];
    int           err_total;

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint coef_mul(longint x, longint c);
        return round_shift(x * c, COEF_FRAC_BITS);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] clip_sample(longint v);
        longint hi, lo;
        hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
        lo = -(longint'(1) << (SAMPLE_BITS - 1));
        if (v > hi)
            v = hi;
        if (v < lo)
            v = lo;
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic stereo_pair_t process_pair(logic signed [SAMPLE_BITS-1:0] l_in,
                                                  logic signed [SAMPLE_BITS-1:0] r_in,
                                                  logic present);
        longint one, wid, pan, alpha, l, r, mid, side, scaled, low_mid, pgl, pgr;
        stereo_pair_t res;
        one   = longint'(1) << COEF_FRAC_BITS;
        wid   = longint'(width_reg);
        pan   = longint'(pan_reg);
        alpha = longint'(alpha_reg);
        if (wid > 2 * one)
            wid = 2 * one;
        if (pan > one)
            pan = one;
        if (pan < -one)
            pan = -one;

        l = longint'(l_in);
        r = present ? longint'(r_in) : l;
        if (pol_reg[POL_LEFT])
            l = -l;
        if (pol_reg[POL_RIGHT])
            r = -r;
        l = coef_mul(l, longint'(gain_reg));
        r = coef_mul(r, longint'(gain_reg));

        mid    = round_shift(l + r, 1);
        side   = round_shift(l - r, 1);
        scaled = coef_mul(side, wid);
        l = mid + scaled;
        r = mid - scaled;

        case (mode_reg)
            MODE_MONO:
            begin
                l = mid;
                r = mid;
            end
            MODE_LOW_MONO:
            begin
                lp_left_a  += coef_mul(l - lp_left_a, alpha);
                lp_left_b  += coef_mul(lp_left_a - lp_left_b, alpha);
                lp_right_a += coef_mul(r - lp_right_a, alpha);
                lp_right_b += coef_mul(lp_right_a - lp_right_b, alpha);
                low_mid = round_shift(lp_left_b + lp_right_b, 1);
                l = low_mid + (l - lp_left_b);
                r = low_mid + (r - lp_right_b);
            end
            default:
            begin
            end
        endcase

        pgl = (pan <= 0) ? one : one - pan;
        pgr = (pan >= 0) ? one : one + pan;
        l = coef_mul(l, pgl);
        r = coef_mul(r, pgr);

        res.left   = clip_sample(l);
        res.right  = present ? clip_sample(r) : '0;
        res.rvalid = present;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        stereo_pair_t want;
        if (!rst_n)
        begin
            gain_reg   = GAIN_RST;
            pan_reg    = PAN_RST;
            width_reg  = WIDTH_RST;
            alpha_reg  = ALPHA_RST;
            mode_reg   = MODE_RST;
            pol_reg    = POL_RST;
            lp_left_a  = 0;
            lp_left_b  = 0;
            lp_right_a = 0;
            lp_right_b = 0;
            expected_pairs.delete();
            err_total  = 0;
            pending_results <= 0;
            fail_count      <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_GAIN:     gain_reg  = cfg_data[GAIN_W-1:0];
                    CFG_PAN:      pan_reg   = cfg_data[PAN_W-1:0];
                    CFG_WIDTH:    width_reg = cfg_data[WIDTH_W-1:0];
                    CFG_ALPHA:    alpha_reg = cfg_data[ALPHA_W-1:0];
                    CFG_MODE:     mode_reg  = cfg_data[MODE_W-1:0];
                    CFG_POLARITY: pol_reg   = cfg_data[POL_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (expected_pairs.size() == 0)
                begin
                    if (err_total < 10)
                        $display("%0t: unexpected output beat: left %0d right %0d rvalid %0b",
                                 $time, left_out, right_out, right_valid);
                    err_total++;
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    if (want.left !== left_out || want.right !== right_out
                        || want.rvalid !== right_valid)
                    begin
                        if (err_total < 10)
                            $display({"%0t: output mismatch: left exp %0d got %0d, ",
                                      "right exp %0d got %0d, rvalid exp %0b got %0b"},
                                     $time, want.left, left_out, want.right, right_out,
                                     want.rvalid, right_valid);
                        err_total++;
                    end
                end
            end

            if (in_valid && !in_stall)
                expected_pairs.push_back(process_pair(left_in, right_in, right_present));

            pending_results <= expected_pairs.size();
            fail_count      <= err_total;
        end
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    import stu_pkg::*;

    localparam int SB = 25;
    localparam int CF = 16;

    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 155;
    localparam int LONG_HOLD       = 300;
    localparam int STALL_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 30;

    localparam int COEF_ONE    = 1 << CF;
    localparam int GAIN_TOP    = (1 << GAIN_W) - 1;
    localparam int WIDTH_TOP   = (1 << WIDTH_W) - 1;
    localparam int WIDTH_RATED = 2 * COEF_ONE;
    localparam int ALPHA_TOP   = (1 << ALPHA_W) - 1;
    localparam int PAN_TOP     = (1 << (PAN_W - 1)) - 1;
    localparam int PAN_BOTTOM  = -(1 << (PAN_W - 1));

    localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

    // code three is not named in the package, it behaves as stereo
    localparam logic [MODE_W-1:0] MODE_AS_STEREO = 2'd3;

    localparam logic [POL_W-1:0] FLIP_NONE  = '0;
    localparam logic [POL_W-1:0] FLIP_LEFT  = POL_W'(1 << POL_LEFT);
    localparam logic [POL_W-1:0] FLIP_RIGHT = POL_W'(1 << POL_RIGHT);
    localparam logic [POL_W-1:0] FLIP_BOTH  = FLIP_LEFT | FLIP_RIGHT;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    typedef logic [CFG_DATA_W-1:0] cfg_word_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                   in_valid;
    logic                   in_stall;
    logic signed [SB-1:0]   left_in;
    logic signed [SB-1:0]   right_in;
    logic                   right_present;

    logic                   out_valid;
    logic                   out_stall;
    logic signed [SB-1:0]   left_out;
    logic signed [SB-1:0]   right_out;
    logic                   right_valid;

    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int pending_results;
    int fail_count;

    bit quiet        = 1'b0;
    bit hold_off_now = 1'b0;

    always #5 clk = ~clk;

    stereo_utility_stage_unit #(
        .SAMPLE_BITS    (SB),
        .COEF_FRAC_BITS (CF)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .left_in       (left_in),
        .right_in      (right_in),
        .right_present (right_present),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .left_out      (left_out),
        .right_out     (right_out),
        .right_valid   (right_valid),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    stereo_stage_checker #(
        .SAMPLE_BITS    (SB),
        .COEF_FRAC_BITS (CF)
    ) result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .left_in         (left_in),
        .right_in        (right_in),
        .right_present   (right_present),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .left_out        (left_out),
        .right_out       (right_out),
        .right_valid     (right_valid),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .pending_results (pending_results),
        .fail_count      (fail_count)
    );

    function automatic logic signed [SB-1:0] random_sample();
        logic signed [SB-1:0] v;
        case ($urandom_range(0, 7))
            0: v = SAMPLE_MAX;
            1: v = SAMPLE_MIN;
            2:
            begin
                v = SB'($urandom_range(0, 2047));
                v = v - SB'(1024);
            end
            default: v = SB'($urandom());
        endcase
        return v;
    endfunction

    function automatic int pick_level(int top);
        case ($urandom_range(0, 5))
            0: return 0;
            1: return top;
            2: return $urandom_range(0, 4095);
            default: return $urandom_range(0, top);
        endcase
    endfunction

    // valid stays high after the beat unless an idle burst follows
    task automatic send_pair(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r,
                             input logic p);
        in_valid      <= 1'b1;
        left_in       <= l;
        right_in      <= r;
        right_present <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3))
                @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input cfg_word_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic load_settings(input int gain, input int pan, input int width,
                                 input int alpha, input logic [MODE_W-1:0] mode,
                                 input logic [POL_W-1:0] pol);
        wait_drained();
        write_reg(CFG_GAIN, cfg_word_t'(gain));
        write_reg(CFG_PAN, cfg_word_t'(pan));
        write_reg(CFG_WIDTH, cfg_word_t'(width));
        write_reg(CFG_ALPHA, cfg_word_t'(alpha));
        write_reg(CFG_MODE, cfg_word_t'(mode));
        write_reg(CFG_POLARITY, cfg_word_t'(pol));
        write_reg(CFG_UNUSED_LO, cfg_word_t'($urandom()));
        write_reg(CFG_UNUSED_HI, cfg_word_t'($urandom()));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : receiver
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_now)
            begin
                hold_off_now = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD)
                    @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3))
                    @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int                 pan_val;
        logic [MODE_W-1:0]  mode_val;
        logic [POL_W-1:0]   pol_val;

        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        left_in       <= '0;
        right_in      <= '0;
        right_present <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_GAIN;
        cfg_data      <= '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, sample extremes
        send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
        send_pair(SAMPLE_MIN, SAMPLE_MIN, 1'b1);
        send_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
        send_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
        send_pair(SAMPLE_MAX, 0, 1'b0);

        // full mono, width and pan beyond their rated range, both flips
        load_settings(GAIN_TOP, PAN_TOP, WIDTH_TOP, 0, MODE_MONO, FLIP_BOTH);
        send_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
        send_pair(SAMPLE_MIN, 12345, 1'b0);
        send_pair(-1, 1, 1'b1);

        // mode three, muted gain, pan below minus one
        load_settings(0, PAN_BOTTOM, 0, ALPHA_TOP, MODE_AS_STEREO, FLIP_LEFT);
        send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
        send_pair(123, -456, 1'b1);

        // bass mono with the fastest filter, right absent updates right states
        load_settings(COEF_ONE, COEF_ONE, WIDTH_RATED, ALPHA_TOP, MODE_LOW_MONO, FLIP_RIGHT);
        send_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
        send_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
        send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        send_pair(1000, -1000, 1'b1);

        // stereo: filter states must hold across this
        load_settings(COEF_ONE, -COEF_ONE, COEF_ONE, ALPHA_RST, MODE_STEREO, FLIP_NONE);
        send_pair(SAMPLE_MAX, 0, 1'b1);
        send_pair(0, SAMPLE_MIN, 1'b1);

        load_settings(COEF_ONE, 0, COEF_ONE, 30000, MODE_LOW_MONO, FLIP_NONE);
        send_pair(0, 0, 1'b1);
        send_pair(500000, -500000, 1'b1);
        send_pair(SAMPLE_MIN, SAMPLE_MIN, 1'b0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            quiet = (ph >= RANDOM_PHASES - 2);
            case ($urandom_range(0, 4))
                0: pan_val = COEF_ONE;
                1: pan_val = -COEF_ONE;
                2: pan_val = PAN_TOP;
                3: pan_val = PAN_BOTTOM;
                default: pan_val = int'($urandom_range(0, GAIN_TOP)) + PAN_BOTTOM;
            endcase
            mode_val = MODE_W'($urandom_range(0, (1 << MODE_W) - 1));
            pol_val  = POL_W'($urandom_range(0, (1 << POL_W) - 1));
            load_settings(pick_level(GAIN_TOP), pan_val, pick_level(WIDTH_TOP),
                          pick_level(ALPHA_TOP), mode_val, pol_val);
            // output side backs up long enough to fill the block
            if (ph == 1)
                hold_off_now = 1'b1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_pair(random_sample(), random_sample(), $urandom_range(0, 7) != 0);
        end

        wait_drained();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
